// File: sv/kce_pkg.sv
// kce_pkg: shared types, codes and constants for the keypad code entry controller
// no dependencies; used by kce_parse and keypad_code_entry_controller
package kce_pkg;

    localparam int MAX_DIGITS  = 9;
    localparam int CODE_DIGITS = 6;
    localparam int MIN_LENGTH  = CODE_DIGITS + 1;

    localparam int LEN_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int ID_W   = 10;
    localparam int CODE_W = 20;
    localparam int SEQ_W  = 32;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RESET   = 16'd10000;
    localparam logic [TICK_W-1:0] VERIFY_TIMEOUT_RESET = 16'd2000;
    localparam logic [TICK_W-1:0] TICK_MAX             = '1;

    // operation codes
    localparam logic [1:0] OP_KEY     = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_VERDICT = 2'd2;

    // key codes
    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_A         = 4'd10;
    localparam logic [3:0] KEY_STAR      = 4'd14;
    localparam logic [3:0] KEY_HASH      = 4'd15;

    // sound codes
    localparam logic [2:0] SND_NONE   = 3'd0;
    localparam logic [2:0] SND_SHORT  = 3'd1;
    localparam logic [2:0] SND_MEDIUM = 3'd2;
    localparam logic [2:0] SND_FAIL   = 3'd3;
    localparam logic [2:0] SND_OPEN   = 3'd4;
    localparam logic [2:0] SND_BELL   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERIFY_TIMEOUT = 2'd1;

    typedef logic [MAX_DIGITS-1:0][3:0] t_digits;

    typedef struct packed {
        logic [1:0]       operation;
        logic [3:0]       key_code;
        logic [SEQ_W-1:0] verdict_seq;
        logic             verdict_granted;
    } t_in;

    typedef struct packed {
        logic [2:0]        sound;
        logic              latch_pulse;
        logic              request_valid;
        logic [ID_W-1:0]   req_id;
        logic [CODE_W-1:0] req_code;
        logic [SEQ_W-1:0]  req_seq;
    } t_out;

    // constant decimal weights
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < 19; k++) begin
            if (k < n) begin
                p = p * 64'd10;
            end
        end
        return p;
    endfunction

endpackage

// File: sv/keypad_code_entry_controller.sv
// keypad_code_entry_controller: key entry, idle/verify timeouts, verify requests
// input is registered, then processed into the output register behind o_out_valid, which holds until i_out_ready
// throughput: one item per cycle while the output is accepted; input ready depends combinationally on output ready
// reset (synchronous, active low): entry, counters, wait flag and sequence cleared,
// timeouts back to 10000 and 2000 ticks; digit store is not cleared
// depends on kce_pkg and kce_parse
module keypad_code_entry_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  kce_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output kce_pkg::t_out                   o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kce_pkg::TICK_W-1:0]      i_cfg_data
);

    logic                          r_in_vld;
    kce_pkg::t_in                  r_in;
    logic                          r_out_vld;
    kce_pkg::t_out                 r_out;
    logic [kce_pkg::TICK_W-1:0]    r_idle_to;
    logic [kce_pkg::TICK_W-1:0]    r_verify_to;
    kce_pkg::t_digits              r_digit;
    logic [kce_pkg::LEN_W-1:0]     r_len;
    logic [kce_pkg::TICK_W-1:0]    r_idle_cnt;
    logic                          r_await;
    logic [kce_pkg::TICK_W-1:0]    r_wait_cnt;
    logic [kce_pkg::SEQ_W-1:0]     r_seq;

    logic [kce_pkg::LEN_W-1:0]     n_len;
    logic [kce_pkg::TICK_W-1:0]    n_idle_cnt;
    logic                          n_await;
    logic [kce_pkg::TICK_W-1:0]    n_wait_cnt;
    logic [kce_pkg::SEQ_W-1:0]     n_seq;
    kce_pkg::t_out                 n_out;
    logic                          digit_wr;

    logic                          proceed;
    logic [kce_pkg::ID_W-1:0]      parsed_id;
    logic [kce_pkg::CODE_W-1:0]    parsed_code;
    logic [kce_pkg::TICK_W-1:0]    idle_inc;
    logic [kce_pkg::TICK_W-1:0]    wait_inc;
    logic [kce_pkg::SEQ_W-1:0]     seq_inc;

    assign proceed     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || proceed;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    kce_parse u_parse (
        .i_digits (r_digit),
        .i_length (r_len),
        .o_id     (parsed_id),
        .o_code   (parsed_code)
    );

    assign idle_inc = (r_idle_cnt < kce_pkg::TICK_MAX) ? r_idle_cnt + 1'b1 : r_idle_cnt;
    assign wait_inc = (r_wait_cnt < kce_pkg::TICK_MAX) ? r_wait_cnt + 1'b1 : r_wait_cnt;
    // sequence numbers skip zero on wrap
    assign seq_inc  = (r_seq + 1'b1 == '0) ? kce_pkg::SEQ_W'(1) : r_seq + 1'b1;

    always_comb begin
        n_len      = r_len;
        n_idle_cnt = r_idle_cnt;
        n_await    = r_await;
        n_wait_cnt = r_wait_cnt;
        n_seq      = r_seq;
        n_out      = '0;
        digit_wr   = 1'b0;
        case (r_in.operation)
            kce_pkg::OP_KEY: begin
                if (!r_await) begin
                    if (r_in.key_code inside {[4'd0:kce_pkg::KEY_DIGIT_MAX]}) begin
                        if (r_len < kce_pkg::LEN_W'(kce_pkg::MAX_DIGITS)) begin
                            digit_wr    = 1'b1;
                            n_len       = r_len + 1'b1;
                            n_out.sound = kce_pkg::SND_SHORT;
                        end else begin
                            n_out.sound = kce_pkg::SND_MEDIUM;
                        end
                        n_idle_cnt = '0;
                    end else if (r_in.key_code == kce_pkg::KEY_A) begin
                        n_out.sound = kce_pkg::SND_BELL;
                    end else if (r_in.key_code == kce_pkg::KEY_STAR) begin
                        n_len       = '0;
                        n_out.sound = kce_pkg::SND_SHORT;
                    end else if (r_in.key_code == kce_pkg::KEY_HASH) begin
                        n_len = '0;
                        if (r_len < kce_pkg::LEN_W'(kce_pkg::MIN_LENGTH)
                            || r_len > kce_pkg::LEN_W'(kce_pkg::MAX_DIGITS)) begin
                            n_out.sound = kce_pkg::SND_FAIL;
                        end else begin
                            n_seq               = seq_inc;
                            n_out.request_valid = 1'b1;
                            n_out.req_id        = parsed_id;
                            n_out.req_code      = parsed_code;
                            n_out.req_seq       = seq_inc;
                            n_await             = 1'b1;
                            n_wait_cnt          = '0;
                        end
                    end
                end
            end
            kce_pkg::OP_TICK: begin
                if (r_await) begin
                    n_wait_cnt = wait_inc;
                    if (wait_inc >= r_verify_to) begin
                        n_out.sound = kce_pkg::SND_FAIL;
                        n_await     = 1'b0;
                        n_wait_cnt  = '0;
                    end
                end else if (r_len != '0) begin
                    n_idle_cnt = idle_inc;
                    // untouched entry times out silently
                    if (idle_inc >= r_idle_to) begin
                        n_len      = '0;
                        n_idle_cnt = '0;
                    end
                end
            end
            kce_pkg::OP_VERDICT: begin
                if (r_await && r_in.verdict_seq == r_seq) begin
                    if (r_in.verdict_granted) begin
                        n_out.sound       = kce_pkg::SND_OPEN;
                        n_out.latch_pulse = 1'b1;
                    end else begin
                        n_out.sound = kce_pkg::SND_FAIL;
                    end
                    n_await    = 1'b0;
                    n_wait_cnt = '0;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_idle_to   <= kce_pkg::IDLE_TIMEOUT_RESET;
            r_verify_to <= kce_pkg::VERIFY_TIMEOUT_RESET;
            r_len       <= '0;
            r_idle_cnt  <= '0;
            r_await     <= 1'b0;
            r_wait_cnt  <= '0;
            r_seq       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (proceed) begin
                r_out_vld  <= 1'b1;
                r_len      <= n_len;
                r_idle_cnt <= n_idle_cnt;
                r_await    <= n_await;
                r_wait_cnt <= n_wait_cnt;
                r_seq      <= n_seq;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == kce_pkg::REG_IDLE_TIMEOUT) begin
                    r_idle_to <= i_cfg_data;
                end else if (i_cfg_index == kce_pkg::REG_VERIFY_TIMEOUT) begin
                    r_verify_to <= i_cfg_data;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (proceed) begin
            r_out <= n_out;
        end
        if (proceed && digit_wr) begin
            r_digit[r_len[kce_pkg::IDX_W-1:0]] <= r_in.key_code;
        end
    end

endmodule

// File: sv/kce_parse.sv
// kce_parse: splits a stored entry into decimal ID and trailing code
// depends on kce_pkg; pure combinational, results kept modulo field width
module kce_parse (
    input  kce_pkg::t_digits                i_digits,
    input  logic [kce_pkg::LEN_W-1:0]       i_length,
    output logic [kce_pkg::ID_W-1:0]        o_id,
    output logic [kce_pkg::CODE_W-1:0]      o_code
);

    logic [kce_pkg::LEN_W-1:0]  id_len;
    logic [kce_pkg::ID_W-1:0]   id_sum;
    logic [kce_pkg::CODE_W-1:0] code_sum;
    logic [kce_pkg::LEN_W-1:0]  pos;
    logic [3:0]                 dig;
    logic [63:0]                w;

    assign id_len = i_length - kce_pkg::LEN_W'(kce_pkg::CODE_DIGITS);

    always_comb begin
        id_sum   = '0;
        code_sum = '0;
        pos      = '0;
        dig      = '0;
        w        = '0;
        // leading id digits, most significant first
        for (int i = 0; i < kce_pkg::MAX_DIGITS - kce_pkg::CODE_DIGITS; i++) begin
            if (kce_pkg::LEN_W'(i) < id_len) begin
                id_sum = kce_pkg::ID_W'(id_sum * kce_pkg::ID_W'(10))
                       + {{(kce_pkg::ID_W-4){1'b0}}, i_digits[i]};
            end
        end
        // trailing code digits start right after the id
        for (int j = 0; j < kce_pkg::CODE_DIGITS; j++) begin
            pos = id_len + kce_pkg::LEN_W'(j);
            if (pos < kce_pkg::LEN_W'(kce_pkg::MAX_DIGITS)) begin
                dig = i_digits[pos[kce_pkg::IDX_W-1:0]];
            end else begin
                dig = '0;
            end
            w        = kce_pkg::pow10(kce_pkg::CODE_DIGITS - 1 - j);
            code_sum = code_sum
                     + kce_pkg::CODE_W'({{(kce_pkg::CODE_W-4){1'b0}}, dig}
                                        * w[kce_pkg::CODE_W-1:0]);
        end
    end

    assign o_id   = id_sum;
    assign o_code = code_sum;

endmodule
